// File: hdl/spq_pkg.sv
// Shared constants and types for the stable priority queue.
// Used by the controller, datapath, top level and checker; no dependencies.
package spq_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int TDATA_W  = 48;

    localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // read address source, logical index from the head
    localparam logic [1:0] RD_HEAD = 2'd0;
    localparam logic [1:0] RD_TAIL = 2'd1;
    localparam logic [1:0] RD_KM2  = 2'd2;

    typedef struct packed {
        logic [PRIO_W-1:0]         prio;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic                capture;
        logic                clr_result;
        logic [STATUS_W-1:0] status;
        logic                ld_head_result;
        logic                rd_en;
        logic [1:0]          rd_sel;
        logic                wr_en;
        logic                wr_new;
        logic                k_load;
        logic                k_dec;
        logic                head_inc;
        logic                count_inc;
        logic                count_dec;
        logic                out_load;
    } spq_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             empty;
        logic             k_is_one;
        logic             head_le;
        logic             out_free;
    } spq_stat_t;

endpackage

// File: hdl/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/spq_ctrl.sv
// Controller state machine of the stable priority queue.
// Depends on spq_pkg; drives the datapath through spq_cmd_t.
module spq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_valid,
    output logic              s_ready,
    input  spq_pkg::spq_stat_t stat,
    output spq_pkg::spq_cmd_t  ctl
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_HEAD  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_PLACE = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctl        = '0;
        ctl.status = spq_pkg::ST_OK;
        ctl.rd_sel = spq_pkg::RD_HEAD;
        s_ready    = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                ctl.clr_result = 1'b1;
                if (stat.cmd == spq_pkg::CMD_ENQ)
                begin
                    if (stat.full)
                    begin
                        ctl.status = spq_pkg::ST_FULL;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        ctl.k_load = 1'b1;
                        if (stat.empty)
                        begin
                            state_next = S_PLACE;
                        end
                        else
                        begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_sel = spq_pkg::RD_TAIL;
                            state_next = S_SCAN;
                        end
                    end
                end
                else if (stat.cmd == spq_pkg::CMD_DEQ || stat.cmd == spq_pkg::CMD_PEEK)
                begin
                    if (stat.empty)
                    begin
                        ctl.status = spq_pkg::ST_EMPTY;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        ctl.rd_en  = 1'b1;
                        ctl.rd_sel = spq_pkg::RD_HEAD;
                        state_next = S_HEAD;
                    end
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_HEAD:
            begin
                ctl.ld_head_result = 1'b1;
                if (stat.cmd == spq_pkg::CMD_DEQ)
                begin
                    ctl.head_inc  = 1'b1;
                    ctl.count_dec = 1'b1;
                end
                state_next = S_RESP;
            end
            S_SCAN:
            begin
                if (stat.head_le)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    // shift the entry below slot k up one slot
                    ctl.wr_en = 1'b1;
                    ctl.k_dec = 1'b1;
                    if (stat.k_is_one)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        ctl.rd_en  = 1'b1;
                        ctl.rd_sel = spq_pkg::RD_KM2;
                    end
                end
            end
            S_PLACE:
            begin
                ctl.wr_en     = 1'b1;
                ctl.wr_new    = 1'b1;
                ctl.count_inc = 1'b1;
                state_next    = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/spq_datapath.sv
// Datapath of the stable priority queue: request capture, circular sorted
// store in spq_ram, head/count/index registers and the output register.
// Depends on spq_pkg and spq_ram.
module spq_datapath #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [spq_pkg::TDATA_W-1:0] s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [spq_pkg::TDATA_W-1:0] m_data,
    input  spq_pkg::spq_cmd_t           ctl,
    output spq_pkg::spq_stat_t          stat
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CXW = CW + spq_pkg::COUNT_W;

    logic [spq_pkg::CMD_W-1:0]    cmd_reg;
    logic [spq_pkg::VALUE_W-1:0]  val_reg;
    logic [spq_pkg::PRIO_W-1:0]   pri_reg;
    logic [AW-1:0]                k_reg;
    logic [AW-1:0]                head_reg;
    logic [CW-1:0]                count_reg;
    logic [spq_pkg::STATUS_W-1:0] res_status_reg;
    logic [spq_pkg::VALUE_W-1:0]  res_value_reg;
    logic [spq_pkg::PRIO_W-1:0]   res_prio_reg;
    logic                         m_valid_reg;
    logic [spq_pkg::TDATA_W-1:0]  m_data_reg;

    logic [AW-1:0]           rd_log;
    logic [AW-1:0]           rd_phys;
    logic [AW-1:0]           wr_phys;
    spq_pkg::entry_t         new_entry;
    spq_pkg::entry_t         rd_entry;
    logic [spq_pkg::ENTRY_W-1:0] rdata;
    logic [spq_pkg::ENTRY_W-1:0] wdata;
    logic [CXW-1:0]          cnt_ext;

    function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] head,
                                              input logic [AW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= (AW+1)'(CAPACITY))
        begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    always_comb
    begin
        unique case (ctl.rd_sel)
            spq_pkg::RD_TAIL: rd_log = AW'(count_reg - CW'(1));
            spq_pkg::RD_KM2:  rd_log = k_reg - AW'(2);
            default:          rd_log = '0;
        endcase
    end

    assign rd_phys         = to_phys(head_reg, rd_log);
    assign wr_phys         = to_phys(head_reg, k_reg);
    assign new_entry.prio  = pri_reg;
    assign new_entry.value = val_reg;
    assign rd_entry        = rdata;
    assign wdata           = ctl.wr_new ? new_entry : rdata;

    spq_ram #(
        .WIDTH (spq_pkg::ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ctl.wr_en),
        .waddr (wr_phys),
        .wdata (wdata),
        .re    (ctl.rd_en),
        .raddr (rd_phys),
        .rdata (rdata)
    );

    assign stat.cmd      = cmd_reg;
    assign stat.full     = (count_reg == CW'(CAPACITY));
    assign stat.empty    = (count_reg == '0);
    assign stat.k_is_one = (k_reg == AW'(1));
    assign stat.head_le  = (rd_entry.prio <= pri_reg);
    assign stat.out_free = !m_valid_reg || m_ready;

    assign cnt_ext = CXW'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.head_inc)
            begin
                head_reg <= (head_reg == AW'(CAPACITY - 1)) ? '0 : head_reg + AW'(1);
            end
            if (ctl.count_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (ctl.count_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (ctl.out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= s_data[1:0];
            val_reg <= s_data[33:2];
            pri_reg <= s_data[41:34];
        end
        if (ctl.k_load)
        begin
            k_reg <= AW'(count_reg);
        end
        else if (ctl.k_dec)
        begin
            k_reg <= k_reg - AW'(1);
        end
        if (ctl.clr_result)
        begin
            res_status_reg <= ctl.status;
            res_value_reg  <= '0;
            res_prio_reg   <= '0;
        end
        else if (ctl.ld_head_result)
        begin
            res_value_reg <= rd_entry.value;
            res_prio_reg  <= rd_entry.prio;
        end
        if (ctl.out_load)
        begin
            m_data_reg <= {count_reg == '0, cnt_ext[spq_pkg::COUNT_W-1:0],
                           res_prio_reg, res_value_reg, res_status_reg};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: hdl/stable_priority_queue_unit.sv
// Stable priority queue top level: one request in, one result out.
// An empty peek/dequeue, a full enqueue or the unused command code goes straight to the result;
// peek/dequeue reads the head entry; enqueue into a non-empty queue first moves the larger-
// priority entries up one slot, one per cycle, then writes the new entry behind its equals.
// Throughput: one request at a time; the next is taken the cycle after the result loads.
// Reset clears count, head, handshake state; RAM not cleared. Uses spq_pkg, spq_ctrl, spq_datapath.
module stable_priority_queue_unit #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [1:0] cmd, [33:2] in_value, [41:34] in_priority, [47:42] zero
    input  logic [spq_pkg::TDATA_W-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [1:0] status, [33:2] out_value, [41:34] out_priority,
    // [46:42] entry_count, [47] is_empty
    output logic [spq_pkg::TDATA_W-1:0] m_axis_tdata
);

    spq_pkg::spq_cmd_t  ctl;
    spq_pkg::spq_stat_t stat;

    spq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .stat    (stat),
        .ctl     (ctl)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_data  (s_axis_tdata),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_axis_tdata),
        .ctl     (ctl),
        .stat    (stat)
    );

endmodule

// File: hdl/spq_checker.sv
// Port-level checker for stable_priority_queue_unit, with its bind.
// Depends on spq_pkg.
module spq_checker #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [spq_pkg::TDATA_W-1:0] s_axis_tdata,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [spq_pkg::TDATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in progress");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != spq_pkg::ST_OK
        |-> m_axis_tdata[41:2] == '0)
        else $error("failed request reports a head entry");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && CAPACITY < 32
        |-> m_axis_tdata[47] == (m_axis_tdata[46:42] == '0))
        else $error("empty flag disagrees with count");

endmodule

bind stable_priority_queue_unit spq_checker #(
    .CAPACITY (CAPACITY)
) u_spq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
